[src/lph_pkg.sv]
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and codes of the linear probing hash table: command and
// status codes, the controller to datapath command word and the datapath
// status word.
// ----------------------------------------------------------------------------
`default_nettype none

package lph_pkg;

   localparam int KEY_W    = 31;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int VAL_W    = 6;
   localparam int SIZE_W   = 7;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
   localparam logic [VAL_W-1:0]  MOVES_MAX  = 6'd63;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

   localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STS_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] STS_ABSENT  = 2'd2;
   localparam logic [STATUS_W-1:0] STS_FULL    = 2'd3;

   typedef enum logic [1:0] {
      VSEL_ZERO,
      VSEL_POS,
      VSEL_MOVES
   } vsel_type;

   typedef struct packed {
      logic                clr_wr;
      logic                load;
      logic                div_start;
      logic                div_cur;
      logic                probe_init;
      logic                probe_next;
      logic                rd_cur;
      logic                wr_insert;
      logic                wr_free_pos;
      logic                walk_next;
      logic                cur_capture;
      logic                wr_move_gap;
      logic                wr_free_cur;
      logic                set_rsp;
      logic [STATUS_W-1:0] rsp_status;
      vsel_type            rsp_vsel;
   } dp_cmd_type;

   typedef struct packed {
      logic             clr_last;
      logic [CMD_W-1:0] command;
      logic             div_done;
      logic             used;
      logic             key_match;
      logic             cur_match;
      logic             probe_last;
      logic             pos_is_cur;
      logic             walk_end;
   } dp_sts_type;

endpackage

`default_nettype wire

[src/lph_ram.sv]
// ----------------------------------------------------------------------------
// lph_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[src/lph_mod.sv]
// ----------------------------------------------------------------------------
// lph_mod
// Serial remainder unit: key modulo the active table size, one key bit per
// cycle by restoring subtraction.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_mod #(
   parameter int SLOTS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [lph_pkg::KEY_W-1:0]    dividend,
   input  wire logic [$clog2(SLOTS+1)-1:0]   divisor,
   output logic                              done,
   output logic      [$clog2(SLOTS)-1:0]     remainder
);

   localparam int REM_W  = $clog2(SLOTS);
   localparam int DIVS_W = $clog2(SLOTS + 1);
   localparam int BCNT_W = $clog2(lph_pkg::KEY_W + 1);

   logic                      busy_ff, busy_in;
   logic [BCNT_W-1:0]         cnt_ff, cnt_in;
   logic [lph_pkg::KEY_W-1:0] dvd_ff, dvd_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [REM_W:0]            shifted;
   logic [REM_W:0]            divs_ext;

   always_comb begin
      shifted  = {rem_ff, dvd_ff[lph_pkg::KEY_W-1]};
      divs_ext = (REM_W + 1)'(divisor);
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = BCNT_W'(lph_pkg::KEY_W);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - BCNT_W'(1);
            dvd_in = {dvd_ff[lph_pkg::KEY_W-2:0], 1'b0};
            if (shifted >= divs_ext) begin
               rem_in = REM_W'(shifted - divs_ext);
            end else begin
               rem_in = REM_W'(shifted);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = busy_ff && (cnt_ff == '0);
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done |-> ((REM_W + 1)'(rem_ff) < (REM_W + 1)'(divisor)))
      else $error("remainder not below divisor");

endmodule

`default_nettype wire

[src/lph_dp.sv]
// ----------------------------------------------------------------------------
// lph_dp
// Datapath: size register, request and walk registers, slot RAM holding
// {used, key} per slot, remainder unit and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_dp #(
   parameter int SLOTS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [lph_pkg::SIZE_W-1:0]      csr_wr_data,
   input  wire logic [lph_pkg::CMD_W-1:0]       req_command,
   input  wire logic [lph_pkg::KEY_W-1:0]       req_key,
   input  wire lph_pkg::dp_cmd_type             cmd,
   output lph_pkg::dp_sts_type                  sts,
   output logic      [lph_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [lph_pkg::VAL_W-1:0]       rsp_value
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (CNT_W > lph_pkg::SIZE_W) ? CNT_W : lph_pkg::SIZE_W;
   localparam int KEY_W  = lph_pkg::KEY_W;
   localparam int WORD_W = KEY_W + 1;

   logic [lph_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [IDX_W-1:0]             clr_addr_ff, clr_addr_in;
   logic [lph_pkg::CMD_W-1:0]    command_ff, command_in;
   logic [KEY_W-1:0]             key_ff, key_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [IDX_W-1:0]             pos_ff, pos_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [IDX_W-1:0]             gap_ff, gap_in;
   logic [IDX_W-1:0]             cur_ff, cur_in;
   logic [CNT_W:0]               step_ff, step_in;
   logic [lph_pkg::VAL_W-1:0]    moves_ff, moves_in;
   logic [KEY_W-1:0]             cur_key_ff, cur_key_in;
   logic [lph_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [lph_pkg::VAL_W-1:0]    rsp_value_ff, rsp_value_in;

   logic [CNT_W-1:0]  n_act;
   logic [CNT_W-1:0]  pos_plus, cur_plus;
   logic [IDX_W-1:0]  pos_wrap, cur_wrap;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_word;
   logic [KEY_W-1:0]  rd_key;
   logic [KEY_W-1:0]  dividend;
   logic              div_done;
   logic [IDX_W-1:0]  home;

   lph_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   lph_mod #(
      .SLOTS (SLOTS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (n_ff),
      .done      (div_done),
      .remainder (home)
   );

   assign rd_key   = rd_word[KEY_W-1:0];
   assign dividend = cmd.div_cur ? rd_key : key_ff;
   assign rd_addr  = cmd.rd_cur ? cur_ff : pos_ff;

   always_comb begin
      if (size_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (CMP_W'(size_ff) > CMP_W'(SLOTS)) begin
         n_act = CNT_W'(SLOTS);
      end else begin
         n_act = CNT_W'(size_ff);
      end
      pos_plus = CNT_W'(pos_ff) + CNT_W'(1);
      cur_plus = CNT_W'(cur_ff) + CNT_W'(1);
      pos_wrap = (pos_plus == n_ff) ? '0 : pos_plus[IDX_W-1:0];
      cur_wrap = (cur_plus == n_ff) ? '0 : cur_plus[IDX_W-1:0];
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = '0;
      if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
      end else if (cmd.wr_insert) begin
         wr_en   = 1'b1;
         wr_data = {1'b1, key_ff};
      end else if (cmd.wr_free_pos) begin
         wr_en   = 1'b1;
      end else if (cmd.wr_move_gap) begin
         wr_en   = 1'b1;
         wr_addr = gap_ff;
         wr_data = {1'b1, cur_key_ff};
      end else if (cmd.wr_free_cur) begin
         wr_en   = 1'b1;
         wr_addr = cur_ff;
      end
   end

   always_comb begin
      size_in       = csr_wr_en ? csr_wr_data : size_ff;
      clr_addr_in   = cmd.clr_wr ? (clr_addr_ff + IDX_W'(1)) : clr_addr_ff;
      command_in    = cmd.load ? req_command : command_ff;
      key_in        = cmd.load ? req_key : key_ff;
      n_in          = cmd.load ? n_act : n_ff;
      cur_key_in    = cmd.cur_capture ? rd_key : cur_key_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      gap_in        = gap_ff;
      cur_in        = cur_ff;
      step_in       = step_ff;
      moves_in      = moves_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (cmd.probe_init) begin
         pos_in = home;
         cnt_in = '0;
      end else if (cmd.probe_next) begin
         pos_in = pos_wrap;
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.wr_free_pos) begin
         gap_in   = pos_ff;
         cur_in   = pos_ff;
         step_in  = '0;
         moves_in = '0;
      end else if (cmd.walk_next) begin
         cur_in  = cur_wrap;
         step_in = step_ff + (CNT_W + 1)'(1);
      end else if (cmd.wr_free_cur) begin
         gap_in = cur_ff;
         if (moves_ff != lph_pkg::MOVES_MAX) begin
            moves_in = moves_ff + lph_pkg::VAL_W'(1);
         end
      end
      if (cmd.set_rsp) begin
         rsp_status_in = cmd.rsp_status;
         case (cmd.rsp_vsel)
            lph_pkg::VSEL_POS:   rsp_value_in = lph_pkg::VAL_W'(pos_ff);
            lph_pkg::VSEL_MOVES: rsp_value_in = moves_ff;
            default:             rsp_value_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= lph_pkg::SIZE_RESET;
         clr_addr_ff <= '0;
      end else begin
         size_ff     <= size_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff    <= command_in;
      key_ff        <= key_in;
      n_ff          <= n_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      gap_ff        <= gap_in;
      cur_ff        <= cur_in;
      step_ff       <= step_in;
      moves_ff      <= moves_in;
      cur_key_ff    <= cur_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_comb begin
      sts.clr_last   = (clr_addr_ff == IDX_W'(SLOTS - 1));
      sts.command    = command_ff;
      sts.div_done   = div_done;
      sts.used       = rd_word[KEY_W];
      sts.key_match  = (rd_key == key_ff);
      sts.cur_match  = (rd_key == cur_key_ff);
      sts.probe_last = ((cnt_ff + CNT_W'(1)) == n_ff);
      sts.pos_is_cur = (pos_ff == cur_ff);
      sts.walk_end   = (step_ff == {n_ff, 1'b0});
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

endmodule

`default_nettype wire

[src/lph_ctrl.sv]
// ----------------------------------------------------------------------------
// lph_ctrl
// Controller: clearing pass, probe sequencing, backward shift walk after a
// delete, and the response handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire lph_pkg::dp_sts_type sts,
   output lph_pkg::dp_cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV_KEY,
      ST_PRB_RD,
      ST_PRB_CHK,
      ST_WALK,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_DIV_CUR,
      ST_IP_RD,
      ST_IP_CHK,
      ST_MOVE_GAP,
      ST_MOVE_CUR,
      ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lph_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   lph_pkg::vsel_type            res_vsel_ff, res_vsel_in;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      res_status_in = res_status_ff;
      res_vsel_in   = res_vsel_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.command == lph_pkg::CMD_NONE) begin
               res_status_in = lph_pkg::STS_OK;
               res_vsel_in   = lph_pkg::VSEL_ZERO;
               state_in      = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_KEY;
            end
         end
         ST_DIV_KEY: begin
            if (sts.div_done) begin
               cmd.probe_init = 1'b1;
               state_in       = ST_PRB_RD;
            end
         end
         ST_PRB_RD: begin
            state_in = ST_PRB_CHK;
         end
         ST_PRB_CHK: begin
            if (!sts.used) begin
               if (sts.command == lph_pkg::CMD_INSERT) begin
                  cmd.wr_insert = 1'b1;
                  res_status_in = lph_pkg::STS_OK;
                  res_vsel_in   = lph_pkg::VSEL_POS;
               end else begin
                  res_status_in = lph_pkg::STS_ABSENT;
                  res_vsel_in   = lph_pkg::VSEL_ZERO;
               end
               state_in = ST_FINISH;
            end else if (sts.key_match) begin
               if (sts.command == lph_pkg::CMD_DELETE) begin
                  cmd.wr_free_pos = 1'b1;
                  state_in        = ST_WALK;
               end else begin
                  res_status_in = (sts.command == lph_pkg::CMD_INSERT) ?
                                  lph_pkg::STS_PRESENT : lph_pkg::STS_OK;
                  res_vsel_in   = lph_pkg::VSEL_POS;
                  state_in      = ST_FINISH;
               end
            end else if (sts.probe_last) begin
               res_status_in = (sts.command == lph_pkg::CMD_INSERT) ?
                               lph_pkg::STS_FULL : lph_pkg::STS_ABSENT;
               res_vsel_in   = lph_pkg::VSEL_ZERO;
               state_in      = ST_FINISH;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_PRB_RD;
            end
         end
         ST_WALK: begin
            if (sts.walk_end) begin
               res_status_in = lph_pkg::STS_OK;
               res_vsel_in   = lph_pkg::VSEL_MOVES;
               state_in      = ST_FINISH;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            cmd.rd_cur = 1'b1;
            state_in   = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            if (!sts.used) begin
               res_status_in = lph_pkg::STS_OK;
               res_vsel_in   = lph_pkg::VSEL_MOVES;
               state_in      = ST_FINISH;
            end else begin
               cmd.cur_capture = 1'b1;
               cmd.div_start   = 1'b1;
               cmd.div_cur     = 1'b1;
               state_in        = ST_DIV_CUR;
            end
         end
         ST_DIV_CUR: begin
            if (sts.div_done) begin
               cmd.probe_init = 1'b1;
               state_in       = ST_IP_RD;
            end
         end
         ST_IP_RD: begin
            state_in = ST_IP_CHK;
         end
         ST_IP_CHK: begin
            if (!sts.used || sts.cur_match || sts.probe_last) begin
               if (sts.used && sts.cur_match && sts.pos_is_cur) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_MOVE_GAP;
               end
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_IP_RD;
            end
         end
         ST_MOVE_GAP: begin
            cmd.wr_move_gap = 1'b1;
            state_in        = ST_MOVE_CUR;
         end
         ST_MOVE_CUR: begin
            cmd.wr_free_cur = 1'b1;
            state_in        = ST_WALK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.set_rsp    = 1'b1;
               cmd.rsp_status = res_status_ff;
               cmd.rsp_vsel   = res_vsel_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_valid_ff  <= 1'b0;
         res_status_ff <= lph_pkg::STS_OK;
         res_vsel_ff   <= lph_pkg::VSEL_ZERO;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_status_ff <= res_status_in;
         res_vsel_ff   <= res_vsel_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_DIV_KEY || state_ff == ST_DIV_CUR))
      else $error("remainder done while not waiting for it");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clearing pass");

endmodule

`default_nettype wire

[src/linear_probe_hash_table_top.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressed hash table of 31-bit keys with linear probing and
// backward shift delete.
//
// Request channel (req_): command and key, taken when req_valid is high
// and req_stall is low. Response channel (rsp_): status and value, one word
// per request, held while rsp_stall is high. The csr_ port writes the
// table size; write it only while the block is idle.
// After reset a clearing pass empties the slot RAM; req_stall stays high
// during it. The block works on one request at a time.
// An insert or find passes through a dispatch step, a bit-serial remainder
// of the key, a registered RAM read and check for each probed slot, and a
// finish step that raises rsp_valid. A delete then walks the cluster: each
// entry is re-probed from its home slot and moved into the gap where
// needed. Once the response is raised the block is idle again and takes
// the next request.
// A new request is taken while the previous response still waits; the
// finished response then waits in the controller until rsp_stall drops.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table_top #(
   parameter int SLOTS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [lph_pkg::SIZE_W-1:0]   csr_wr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [lph_pkg::CMD_W-1:0]    req_command,
   input  wire logic [lph_pkg::KEY_W-1:0]    req_key,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [lph_pkg::STATUS_W-1:0] rsp_status,
   output logic      [lph_pkg::VAL_W-1:0]    rsp_value
);

   lph_pkg::dp_cmd_type cmd;
   lph_pkg::dp_sts_type sts;

   lph_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_command (req_command),
      .req_key     (req_key),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_status  (rsp_status),
      .rsp_value   (rsp_value)
   );

   lph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

endmodule

`default_nettype wire
